// File: rtl/bcm_pkg.sv
package bcm_pkg;

    localparam int SampleW = 10;
    localparam int VoltW   = 24;
    localparam int CurrW   = 26;
    localparam int CapW    = 36;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 20;

    typedef enum logic [2:0] {
        CFG_BATT_SCALE  = 3'd0,
        CFG_CHG_SCALE   = 3'd1,
        CFG_MODE        = 3'd2,
        CFG_ZERO        = 3'd3,
        CFG_DIVISOR     = 3'd4,
        CFG_SENS        = 3'd5,
        CFG_CORR        = 3'd6,
        CFG_INVERT      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_HALL  = 2'd1,
        MODE_SHUNT = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP,
        ST_BV,
        ST_BF,
        ST_CV,
        ST_CF,
        ST_SH,
        ST_N,
        ST_E,
        ST_NUM,
        ST_DEN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [SampleW-1:0] battery_sample;
        logic [SampleW-1:0] charge_volt_sample;
        logic [SampleW-1:0] current_sample;
    } t_in_word;

    typedef struct packed {
        logic [VoltW-1:0] battery_voltage;
        logic [VoltW-1:0] charge_voltage;
        logic [CurrW-1:0] charge_current;
        logic [CapW-1:0]  charged_capacity;
    } t_out_word;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CfgW-1:0]    data;
    } t_cfg_word;

    localparam logic [CurrW-1:0] MinCurr  = 26'd2621;
    localparam logic [VoltW-1:0] FiveVolt = 24'd327680;

    // reciprocals: floor(x/d) = (x * ceil(2^k/d)) >> k over the operand ranges used
    localparam logic [31:0] Recip36   = 32'd119304648;   // k = 32, x < 2^26
    localparam logic [31:0] Recip100  = 32'd2748779070;  // k = 38, x < 100*2^24
    localparam logic [31:0] Recip1023 = 32'd2149582851;  // k = 41, x < 2^29

endpackage

// File: rtl/bcm_stream_if.sv
interface bcm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/battery_charge_monitor_unit.sv
// Battery charge monitor.
// Channels: i_in (sink) takes one word of three 10-bit ADC samples; o_out
// (source) gives one word of filtered voltages, current and capacity per
// input word; i_cfg (sink) writes one register by index and is always ready.
// Datapath: a small sequencer runs the main products over one shared 32x32
// multiplier; the divisions by 36, 100 and 1023 are reciprocal products and
// the hall current uses a restoring divider, one quotient bit per cycle.
// o_out.valid rises after the ST_OUT step; hall mode runs the divider before it
// and skips the divider when the hall current is forced to zero.
// Throughput: one item in flight; i_in.ready is high only when idle with no
// word waiting, so the next word is taken the cycle after the result is taken.
// The result sits in the output registers until taken; while the receiver
// stalls the block holds the word and takes no new input.
// Reset (i_rst_n low, synchronous) clears all levels and the capacity to
// zero and loads the register defaults.
module battery_charge_monitor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcm_stream_if.sink   i_in,
    bcm_stream_if.source o_out,
    bcm_stream_if.sink   i_cfg
);
    import bcm_pkg::*;

    localparam int DivW = 64;
    localparam int DivCntW = 7;

    t_state r_state, n_state;

    logic [19:0] r_bscale, r_cscale;
    logic [1:0]  r_mode;
    logic [9:0]  r_zero, r_sens;
    logic [15:0] r_div_cfg;
    logic [7:0]  r_corr;
    logic        r_inv;

    logic [VoltW-1:0] r_blev, r_clev;
    logic [CurrW-1:0] r_ilev;
    logic [CapW-1:0]  r_cap;
    t_in_word         r_in;
    logic             r_out_v;

    // divider for the hall current: quotient, remainder, divisor, bit counter
    logic [DivW-1:0]    r_q, r_dsr;
    logic [DivW:0]      r_rem;
    logic [DivCntW-1:0] r_cnt;
    logic               r_div_busy;
    // shared work registers and flags
    logic [63:0] r_a, r_b;
    logic        r_zero_cur;
    logic        r_cap_en;
    logic        r_snap;

    // shared multiplier
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    // shunt numerator 5*65536*S as shifts
    logic [31:0] shunt_num;
    assign shunt_num = {4'd0, r_in.current_sample, 18'd0}
                     + {6'd0, r_in.current_sample, 16'd0};

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE) && !r_out_v;
    assign o_out.valid = r_out_v;
    assign o_out.data  = '{battery_voltage: r_blev, charge_voltage: r_clev,
                           charge_current: r_ilev, charged_capacity: r_cap};

    logic [DivW:0] rem_sh;
    assign rem_sh = {r_rem[DivW-1:0], r_q[DivW-1]};

    // sequencer: selects multiplier operands and next state
    always_comb begin
        n_state = r_state;
        mul_x = '0;
        mul_y = '0;
        unique case (r_state)
            ST_IDLE: if (i_in.valid && i_in.ready) n_state = ST_CAP;
            ST_CAP: begin
                mul_x = {6'd0, r_ilev};
                mul_y = Recip36;
                n_state = ST_BV;
            end
            ST_BV: begin
                mul_x = {22'd0, r_in.battery_sample};
                mul_y = {12'd0, r_bscale};
                n_state = ST_BF;
            end
            ST_BF: begin
                mul_x = r_a[31:0];
                mul_y = Recip100;
                n_state = ST_CV;
            end
            ST_CV: begin
                mul_x = {22'd0, r_in.charge_volt_sample};
                mul_y = {12'd0, r_cscale};
                n_state = ST_CF;
            end
            ST_CF: begin
                mul_x = r_a[31:0];
                mul_y = Recip100;
                n_state = (r_mode == MODE_HALL) ? ST_N :
                          (r_mode == MODE_SHUNT) ? ST_SH : ST_OUT;
            end
            ST_SH: begin
                mul_x = shunt_num;
                mul_y = Recip1023;
                n_state = ST_OUT;
            end
            ST_N: begin
                mul_x = {22'd0, r_in.current_sample};
                mul_y = {16'd0, r_div_cfg};
                n_state = ST_E;
            end
            ST_E: begin
                mul_x = {22'd0, r_zero};
                mul_y = {22'd0, r_sens};
                n_state = ST_NUM;
            end
            ST_NUM: begin
                mul_x = r_a[31:0];
                mul_y = 32'd330000;
                n_state = ST_DEN;
            end
            ST_DEN: begin
                mul_x = {16'd0, r_div_cfg};
                mul_y = r_b[31:0];
                n_state = ST_DIV;
            end
            ST_DIV:  if (!r_div_busy) n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bscale <= 20'd3244; r_cscale <= 20'd3244; r_mode <= MODE_RAW;
            r_zero <= 10'd511; r_div_cfg <= 16'd512; r_sens <= 10'd185;
            r_corr <= 8'd39; r_inv <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.data.index))
                CFG_BATT_SCALE: r_bscale  <= i_cfg.data.data;
                CFG_CHG_SCALE:  r_cscale  <= i_cfg.data.data;
                CFG_MODE:       r_mode    <= i_cfg.data.data[1:0];
                CFG_ZERO:       r_zero    <= i_cfg.data.data[9:0];
                CFG_DIVISOR:    r_div_cfg <= i_cfg.data.data[15:0];
                CFG_SENS:       r_sens    <= i_cfg.data.data[9:0];
                CFG_CORR:       r_corr    <= i_cfg.data.data[7:0];
                CFG_INVERT:     r_inv     <= i_cfg.data.data[0];
                default: ;
            endcase
        end
    end

    // datapath
    logic [VoltW-1:0] v_sat;
    logic [VoltW-1:0] lev_sel;
    logic [VoltW-1:0] vdiff;
    logic [31:0]      filt_sum;
    logic [CapW:0]    cap_sum;
    logic signed [19:0] corr_fac;
    logic signed [28:0] corr_term;
    logic signed [40:0] e_val;
    logic signed [40:0] n_val;
    assign v_sat    = (|mul_p[63:VoltW]) ? '1 : mul_p[VoltW-1:0];
    assign lev_sel  = (r_state == ST_BV) ? r_blev : r_clev;
    assign vdiff    = (lev_sel > v_sat) ? lev_sel - v_sat : v_sat - lev_sel;
    // 99*level + v + 50, below 100*2^24
    assign filt_sum = {8'd0, lev_sel} * 32'd99 + {8'd0, v_sat} + 32'd50;
    assign cap_sum  = {1'b0, r_cap} + {5'd0, mul_p[63:32]};
    assign n_val    = $signed({1'b0, r_a[39:0]}) - 41'sd261888;
    // E = 100*sens*Z + corr*(337590 - 500*Z)
    assign corr_fac  = 20'sd337590 - $signed({1'b0, r_zero}) * 20'sd500;
    assign corr_term = $signed({1'b0, r_corr}) * corr_fac;
    assign e_val     = $signed({1'b0, mul_p[39:0]}) * 41'sd100 + 41'(corr_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blev <= '0; r_clev <= '0; r_ilev <= '0; r_cap <= '0;
            r_out_v <= 1'b0; r_div_busy <= 1'b0; r_cnt <= '0;
        end else begin
            // raise the word at the last step, drop it once taken
            if (r_state == ST_OUT)   r_out_v <= 1'b1;
            else if (o_out.ready)    r_out_v <= 1'b0;
            // divider: one quotient bit per cycle
            if (r_div_busy) begin
                if (rem_sh >= {1'b0, r_dsr}) begin
                    r_rem <= rem_sh - {1'b0, r_dsr};
                    r_q   <= {r_q[DivW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[DivW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) r_div_busy <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: if (i_in.valid && i_in.ready) begin
                    r_in <= i_in.data;
                    r_cap_en <= (r_ilev > MinCurr) && (r_clev > FiveVolt);
                end
                // capacity growth = current / 36
                ST_CAP: if (r_cap_en)
                    r_cap <= cap_sum[CapW] ? '1 : cap_sum[CapW-1:0];
                ST_BV, ST_CV: begin
                    r_b <= {40'd0, v_sat};
                    r_snap <= vdiff > FiveVolt;
                    r_a <= {32'd0, filt_sum};
                end
                ST_BF: r_blev <= r_snap ? r_b[VoltW-1:0] : mul_p[61:38];
                ST_CF: begin
                    r_clev <= r_snap ? r_b[VoltW-1:0] : mul_p[61:38];
                    if (r_mode == MODE_RAW)
                        r_ilev <= {r_in.current_sample, 16'd0};
                end
                ST_SH: r_ilev <= {3'd0, mul_p[63:41]};
                ST_N: r_a <= mul_p;
                ST_E: begin
                    r_zero_cur <= (r_zero == 10'd0) || (r_div_cfg == 16'd0)
                                || (e_val <= 0)
                                || ((r_inv ? -n_val : n_val) <= 0);
                    r_a <= {23'd0, r_inv ? -n_val : n_val};
                    r_b <= {23'd0, e_val};
                end
                ST_NUM: r_a <= mul_p;  // 330000*N, below 2^45
                ST_DEN: begin
                    r_q <= {r_a[47:0], 16'd0};
                    r_rem <= '0; r_dsr <= mul_p; r_cnt <= 7'd64;
                    r_div_busy <= !r_zero_cur;
                end
                ST_DIV: if (!r_div_busy) begin
                    if (r_zero_cur) r_ilev <= '0;
                    else r_ilev <= (|r_q[63:CurrW]) ? '1 : r_q[CurrW-1:0];
                end
                default: ;
            endcase
        end
    end

    // output word holds while stalled; no divider work while idle, no word while busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !o_out.ready |=> $stable(r_cap))
        else $error("capacity changed under stalled word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> r_state != ST_IDLE)
        else $error("divider busy while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("stalled word changed or dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_state == ST_IDLE)
        else $error("word waiting while busy");
endmodule
